// File: rtl/jtag_tap_shift_capture_macros.svh
// assertion macros for the jtag tap shift and capture block
`ifndef JTAG_TAP_SHIFT_CAPTURE_MACROS_SVH
`define JTAG_TAP_SHIFT_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS

`define JTC_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jtc assertion failed in same cycle");

`define JTC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jtc assertion failed in next cycle");

`else

`define JTC_ASSERT_SAME(lbl, ck, rst_n, ante, cons)

`define JTC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)

`endif

`endif

// File: rtl/jtc_pkg.sv
// shared types and constants for the jtag tap shift and capture block
package jtc_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned HALF_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_EMU = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b1;

	localparam logic [2:0] PAIRS_FULL = 3'd4;
	localparam logic [3:0] BYTE_BITS  = 4'd8;

	typedef struct packed {
		logic [1:0] last_pair;
		logic [3:0] tdo;
		logic [3:0] emu;
		logic       last;
		logic       err;
	} entry_t;

	typedef struct packed {
		logic              capture_emu;
		logic [HALF_W-1:0] half_period;
		logic              clear;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic [2:0] cap_count;
	} bk_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HIGH,
		BK_LOW,
		BK_HOLD
	} bk_state_t;

endpackage

// File: rtl/jtc_front.sv
// front end: accepts requests, checks pair counts and queues them for the back end
module jtc_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       pairs_valid,
	input  logic [3:0]       tdo_bits,
	input  logic [3:0]       emu_bits,
	input  logic             end_of_sequence,
	output jtc_pkg::entry_t  q_head,
	output logic             q_valid,
	input  logic             q_pop,
	output jtc_pkg::q_stat_t q_stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	jtc_pkg::entry_t mem_q [DEPTH];
	jtc_pkg::entry_t entry_in;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] level_q;
	logic             full;
	logic             empty;
	logic             push;
	logic             len_bad;

	// only a final request may clock fewer than four pairs
	assign len_bad = (pairs_valid == 3'd0) || (pairs_valid > jtc_pkg::PAIRS_FULL)
		|| (!end_of_sequence && (pairs_valid != jtc_pkg::PAIRS_FULL));

	always_comb begin
		entry_in.last_pair = 2'(pairs_valid - 3'd1);
		entry_in.tdo       = tdo_bits;
		entry_in.emu       = emu_bits;
		entry_in.last      = end_of_sequence;
		entry_in.err       = len_bad;
	end

	assign full     = (level_q == CNT_FULL);
	assign empty    = (level_q == '0);
	assign in_stall = full;
	assign push     = in_valid && !full;
	assign q_valid  = !empty;
	assign q_head   = mem_q[rd_ptr_q];

	always_comb begin
		q_stat.empty = empty;
		q_stat.full  = full;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (q_pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !(q_pop && !empty)) begin
				level_q <= level_q + CNT_W'(1);
			end else if (!push && q_pop && !empty) begin
				level_q <= level_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/jtc_back.sv
// back end: tck phase timing, bit capture and the result register
module jtc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jtc_pkg::cfg_t     cfg,
	input  jtc_pkg::entry_t   q_head,
	input  logic              q_valid,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        captured_byte,
	output logic              final_byte,
	output logic              length_error,
	output jtc_pkg::bk_stat_t stat
);

	jtc_pkg::bk_state_t state_q;
	jtc_pkg::bk_state_t state_d;
	jtc_pkg::entry_t    cur_q;

	logic [1:0]                   pair_q;
	logic [jtc_pkg::HALF_W-1:0]   timer_q;
	logic [7:0]                   shift_q;
	logic [2:0]                   count_q;
	logic                         full_q;
	logic [7:0]                   full_byte_q;
	logic [7:0]                   pend_byte_q;
	logic                         pend_final_q;
	logic                         pend_err_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_final_q;
	logic                         out_err_q;

	logic       tdo_bit;
	logic       emu_bit;
	logic [7:0] s1;
	logic [7:0] s2;
	logic [2:0] c1;
	logic [2:0] c2;
	logic       f1;
	logic       f2;
	logic       step_full;
	logic [7:0] step_full_byte;
	logic [7:0] res_byte;

	logic timer_zero;
	logic pair_end;
	logic fin;
	logic fin_res;
	logic out_free;
	logic hold_emit;
	logic go_hold;
	logic can_start;
	logic pop;
	logic emit;

	// one pair: tdo bit, then the emu bit in emu mode, entering at the msb
	always_comb begin
		tdo_bit = cur_q.tdo[pair_q];
		emu_bit = cur_q.emu[pair_q];
		s1 = {tdo_bit, shift_q[7:1]};
		c1 = count_q + 3'd1;
		f1 = (c1 == 3'd0);
		if (cfg.capture_emu) begin
			s2 = {emu_bit, s1[7:1]};
			c2 = c1 + 3'd1;
			f2 = (c2 == 3'd0);
		end else begin
			s2 = s1;
			c2 = c1;
			f2 = 1'b0;
		end
		step_full      = full_q || f1 || f2;
		step_full_byte = f2 ? s2 : (f1 ? s1 : full_byte_q);
		// partial byte right-aligned
		res_byte = step_full ? step_full_byte : (s2 >> (jtc_pkg::BYTE_BITS - {1'b0, c2}));
	end

	// control decode
	always_comb begin
		timer_zero = (timer_q == '0);
		pair_end   = (state_q == jtc_pkg::BK_LOW) && timer_zero;
		fin        = pair_end && (pair_q == cur_q.last_pair);
		fin_res    = fin && (step_full || cur_q.last);
		out_free   = !out_valid_q || !out_stall;
		hold_emit  = (state_q == jtc_pkg::BK_HOLD) && out_free;
		go_hold    = fin_res && !out_free;
		can_start  = (state_q == jtc_pkg::BK_IDLE) || (fin && !go_hold) || hold_emit;
		pop        = can_start && q_valid;
		emit       = hold_emit || (fin_res && out_free);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jtc_pkg::BK_IDLE: begin
				if (pop) begin
					state_d = q_head.err ? jtc_pkg::BK_HOLD : jtc_pkg::BK_HIGH;
				end
			end
			jtc_pkg::BK_HIGH: begin
				if (timer_zero) begin
					state_d = jtc_pkg::BK_LOW;
				end
			end
			jtc_pkg::BK_LOW: begin
				if (go_hold) begin
					state_d = jtc_pkg::BK_HOLD;
				end else if (pop) begin
					state_d = q_head.err ? jtc_pkg::BK_HOLD : jtc_pkg::BK_HIGH;
				end else if (fin) begin
					state_d = jtc_pkg::BK_IDLE;
				end else if (pair_end) begin
					state_d = jtc_pkg::BK_HIGH;
				end
			end
			jtc_pkg::BK_HOLD: begin
				if (pop) begin
					state_d = q_head.err ? jtc_pkg::BK_HOLD : jtc_pkg::BK_HIGH;
				end else if (hold_emit) begin
					state_d = jtc_pkg::BK_IDLE;
				end
			end
			default: state_d = jtc_pkg::BK_IDLE;
		endcase
	end

	assign q_pop         = pop;
	assign out_valid     = out_valid_q;
	assign captured_byte = out_byte_q;
	assign final_byte    = out_final_q;
	assign length_error  = out_err_q;

	always_comb begin
		stat.cap_count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jtc_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			shift_q     <= '0;
			count_q     <= '0;
			full_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				full_q <= 1'b0;
			end else if (pair_end) begin
				full_q <= step_full;
			end
			if (cfg.clear) begin
				shift_q <= '0;
				count_q <= '0;
			end else if (pop && q_head.err && q_head.last) begin
				shift_q <= '0;
				count_q <= '0;
			end else if (pair_end) begin
				if (fin && cur_q.last) begin
					shift_q <= '0;
					count_q <= '0;
				end else begin
					shift_q <= s2;
					count_q <= c2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= q_head;
			pair_q  <= '0;
			timer_q <= cfg.half_period;
		end else begin
			if (((state_q == jtc_pkg::BK_HIGH) && timer_zero) || (pair_end && !fin)) begin
				timer_q <= cfg.half_period;
			end else if (((state_q == jtc_pkg::BK_HIGH) || (state_q == jtc_pkg::BK_LOW))
				&& !timer_zero) begin
				timer_q <= timer_q - jtc_pkg::HALF_W'(1);
			end
			if (pair_end && !fin) begin
				pair_q <= pair_q + 2'd1;
			end
		end
		if (pair_end) begin
			full_byte_q <= step_full_byte;
		end
		if (pop && q_head.err) begin
			pend_byte_q  <= '0;
			pend_final_q <= q_head.last;
			pend_err_q   <= 1'b1;
		end else if (go_hold) begin
			pend_byte_q  <= res_byte;
			pend_final_q <= cur_q.last;
			pend_err_q   <= 1'b0;
		end
		if (emit) begin
			out_byte_q  <= hold_emit ? pend_byte_q : res_byte;
			out_final_q <= hold_emit ? pend_final_q : cur_q.last;
			out_err_q   <= hold_emit ? pend_err_q : 1'b0;
		end
	end

endmodule

// File: rtl/jtag_tap_shift_capture.sv
// top level of the jtag tap shift and capture block with its register file
//
//  ch   | role    | handshake           | payload
//  in   | request | in_valid/in_stall   | tap_byte pairs_valid tdo_bits emu_bits end_of_sequence
//  out  | result  | out_valid/out_stall | captured_byte final_byte length_error
//  cfg  | write   | cfg_valid/cfg_ready | cfg_index cfg_data
//
// each pair runs a tck high phase then a tck low phase in the back end, and the tck phase timer
// times each phase from the half period register
// a request with a bad pair count clocks nothing and is reported with length_error
// reset is asynchronous and clears the control state and capture byte, but not the data, timer or pair registers
// out_stall holds the result register; the queue keeps taking requests until it is full
module jtag_tap_shift_capture #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     tap_byte,
	input  logic [2:0]                     pairs_valid,
	input  logic [3:0]                     tdo_bits,
	input  logic [3:0]                     emu_bits,
	input  logic                           end_of_sequence,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     captured_byte,
	output logic                           final_byte,
	output logic                           length_error,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jtc_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "jtag_tap_shift_capture_macros.svh"

	logic                       capture_emu_q;
	logic [jtc_pkg::HALF_W-1:0] half_period_q;
	logic                       cfg_write;
	jtc_pkg::cfg_t              cfg;
	jtc_pkg::entry_t            q_head;
	logic                       q_valid;
	logic                       q_pop;
	jtc_pkg::q_stat_t           q_stat;
	jtc_pkg::bk_stat_t          bk_stat;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_emu_q <= 1'b0;
			half_period_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				jtc_pkg::CFG_CAPTURE_EMU: capture_emu_q <= cfg_data[0];
				jtc_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a mode change drops any half-filled capture byte
	always_comb begin
		cfg.capture_emu = capture_emu_q;
		cfg.half_period = half_period_q;
		cfg.clear       = cfg_write && (cfg_index == jtc_pkg::CFG_CAPTURE_EMU);
	end

	jtc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pairs_valid     (pairs_valid),
		.tdo_bits        (tdo_bits),
		.emu_bits        (emu_bits),
		.end_of_sequence (end_of_sequence),
		.q_head          (q_head),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_stat          (q_stat)
	);

	jtc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_head        (q_head),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.captured_byte (captured_byte),
		.final_byte    (final_byte),
		.length_error  (length_error),
		.stat          (bk_stat)
	);

	`JTC_ASSERT_SAME(a_err_byte_zero, clk, arst_n, out_valid && length_error, captured_byte == 8'h00)
	`JTC_ASSERT_NEXT(a_mode_clears, clk, arst_n, cfg.clear, bk_stat.cap_count == 3'd0)
	`JTC_ASSERT_NEXT(a_accept_queued, clk, arst_n, in_valid && !in_stall, !q_stat.empty)
	`JTC_ASSERT_SAME(a_emu_even, clk, arst_n, capture_emu_q, !bk_stat.cap_count[0])

endmodule
